@@ rtl/core/rtp_frame_reorder_assembler_core_defines.svh @@
// Assertion macros shared by the frame reorder and assembly core.
// Depends on nothing; included by the modules that carry assertions.
`ifndef RTP_FRAME_REORDER_ASSEMBLER_CORE_DEFINES_SVH
`define RTP_FRAME_REORDER_ASSEMBLER_CORE_DEFINES_SVH

// Property that must hold at every clock edge outside reset.
`define RFRA_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// Cause in this cycle implies effect in the next cycle.
`define RFRA_ASSERT_NEXT(lbl, clk, rst, cause, effect, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (cause) |=> (effect)) else $error(msg);

`endif

@@ rtl/core/rfra_pkg.sv @@
// Types, constants and the packet placement function of the frame reorder core.
// Depends on nothing; used by every module of the core.
package rfra_pkg;

   localparam int SEQ_W = 16;
   localparam int LEN_W = 11;
   localparam int OFF_W = 17;
   localparam int MAX_WORDS = 4;
   localparam int CNT_W = 3;

   // Frame buffer size and largest accepted payload
   localparam logic [OFF_W:0] FRAME_BYTES = 18'd65536;
   localparam logic [15:0]    MAX_PAYLOAD = 16'd2047;

   typedef enum logic [1:0] {
      ACT_APPEND_CUR  = 2'd0,
      ACT_APPEND_HELD = 2'd1,
      ACT_COMPLETE    = 2'd2,
      ACT_DROPPED     = 2'd3
   } action_type;

   typedef struct packed {
      logic [SEQ_W-1:0] seq_no;
      logic             marker;
      logic [LEN_W-1:0] payload_len;
   } req_type;

   typedef struct packed {
      action_type       action;
      logic [OFF_W-1:0] byte_offset;
      logic [OFF_W-1:0] frame_length;
      logic             last;
   } rsp_type;

   // Results of one item, handed from the engine to the output queue
   typedef struct packed {
      logic                       load;
      logic [CNT_W-1:0]           count;
      rsp_type [MAX_WORDS-1:0]    words;
   } bundle_type;

   // Outcome of placing one packet into the frame
   typedef struct packed {
      logic             app_v;
      logic [OFF_W-1:0] app_off;
      logic             end_v;
      logic             end_drop;
      logic [OFF_W-1:0] end_len;
      logic             loss;
      logic [OFF_W-1:0] off;
   } place_type;

   function automatic place_type place_packet(logic loss, logic [OFF_W-1:0] off,
                                              logic [LEN_W-1:0] len, logic mark);
      place_type p;
      logic [OFF_W:0] sum;
      sum       = {1'b0, off} + {{(OFF_W+1-LEN_W){1'b0}}, len};
      p         = '0;
      p.loss    = loss;
      p.off     = off;
      p.app_off = off;
      // append unless the frame is already lost or would overflow
      if (!loss) begin
         if (({{(16-LEN_W){1'b0}}, len} > MAX_PAYLOAD) || (sum > FRAME_BYTES)) begin
            p.loss = 1'b1;
         end else begin
            p.app_v = 1'b1;
            p.off   = sum[OFF_W-1:0];
         end
      end
      // close the frame on a marker
      if (mark) begin
         p.end_v    = 1'b1;
         p.end_drop = p.loss;
         p.end_len  = p.loss ? '0 : p.off;
         p.off      = '0;
         p.loss     = 1'b0;
      end
      return p;
   endfunction

endpackage

@@ rtl/core/rfra_engine.sv @@
// Input register, sequence tracking state and the single-pass step logic.
// Depends on rfra_pkg and the assertion macro header.
`include "rtp_frame_reorder_assembler_core_defines.svh"

module rfra_engine (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_ready,
   input  rfra_pkg::req_type   req_payload,
   input  logic                q_free,
   output rfra_pkg::bundle_type bundle
);

   logic                         in_valid_ff, in_valid_in;
   rfra_pkg::req_type            in_ff, in_in;
   logic [rfra_pkg::SEQ_W-1:0]   exp_ff, exp_in;
   logic                         first_ff, first_in;
   logic                         held_v_ff, held_v_in;
   logic [rfra_pkg::LEN_W-1:0]   held_len_ff, held_len_in;
   logic                         held_mark_ff, held_mark_in;
   logic                         loss_ff, loss_in;
   logic [rfra_pkg::OFF_W-1:0]   fill_ff, fill_in;

   logic                         fire;
   logic [rfra_pkg::SEQ_W-1:0]   exp0;
   logic                         hv, loss0, hold;
   rfra_pkg::place_type          p1, p2;
   logic [rfra_pkg::MAX_WORDS-1:0] cv;
   rfra_pkg::rsp_type [rfra_pkg::MAX_WORDS-1:0] cand;
   logic [rfra_pkg::CNT_W-1:0]   n;

   assign fire      = in_valid_ff && q_free;
   assign req_ready = !in_valid_ff || fire;

   // Hold the accepted word until the step has been applied
   always_comb begin
      in_valid_in = in_valid_ff;
      in_in       = in_ff;
      if (fire) begin
         in_valid_in = 1'b0;
      end
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
         in_in       = req_payload;
      end
   end

   // Classify the arrival and place the current and held packets
   always_comb begin
      exp0  = first_ff ? in_ff.seq_no : exp_ff;
      hv    = held_v_ff;
      loss0 = loss_ff;
      hold  = 1'b0;
      if (hv) begin
         if (in_ff.seq_no != exp0 - 16'd2) begin
            loss0 = 1'b1;
            hv    = 1'b0;
         end
      end else if (in_ff.seq_no != exp0) begin
         if (in_ff.seq_no == exp0 + 16'd1) begin
            hold = 1'b1;
         end else begin
            loss0 = 1'b1;
         end
      end
      p1 = rfra_pkg::place_packet(loss0, fill_ff, in_ff.payload_len, in_ff.marker);
      p2 = rfra_pkg::place_packet(p1.loss, p1.off, held_len_ff, held_mark_ff);
   end

   // Advance the tracking state when the step is taken
   always_comb begin
      exp_in       = exp_ff;
      first_in     = first_ff;
      held_v_in    = held_v_ff;
      held_len_in  = held_len_ff;
      held_mark_in = held_mark_ff;
      loss_in      = loss_ff;
      fill_in      = fill_ff;
      if (fire) begin
         first_in = 1'b0;
         if (hold) begin
            held_v_in    = 1'b1;
            held_len_in  = in_ff.payload_len;
            held_mark_in = in_ff.marker;
            exp_in       = in_ff.seq_no + 16'd1;
            loss_in      = loss0;
         end else begin
            held_v_in = 1'b0;
            loss_in   = hv ? p2.loss : p1.loss;
            fill_in   = hv ? p2.off : p1.off;
            exp_in    = hv ? in_ff.seq_no + 16'd2 : in_ff.seq_no + 16'd1;
         end
      end
   end

   // Build the candidate words, mark the final one and pack them
   always_comb begin
      cv[0] = !hold && p1.app_v;
      cv[1] = !hold && p1.end_v;
      cv[2] = !hold && hv && p2.app_v;
      cv[3] = !hold && hv && p2.end_v;

      cand[0].action       = rfra_pkg::ACT_APPEND_CUR;
      cand[0].byte_offset  = p1.app_off;
      cand[0].frame_length = '0;
      cand[0].last         = cv[0] && !(|cv[3:1]);
      cand[1].action       = p1.end_drop ? rfra_pkg::ACT_DROPPED : rfra_pkg::ACT_COMPLETE;
      cand[1].byte_offset  = '0;
      cand[1].frame_length = p1.end_len;
      cand[1].last         = cv[1] && !(|cv[3:2]);
      cand[2].action       = rfra_pkg::ACT_APPEND_HELD;
      cand[2].byte_offset  = p2.app_off;
      cand[2].frame_length = '0;
      cand[2].last         = cv[2] && !cv[3];
      cand[3].action       = p2.end_drop ? rfra_pkg::ACT_DROPPED : rfra_pkg::ACT_COMPLETE;
      cand[3].byte_offset  = '0;
      cand[3].frame_length = p2.end_len;
      cand[3].last         = cv[3];

      bundle.words = '0;
      n = '0;
      for (int i = 0; i < rfra_pkg::MAX_WORDS; i++) begin
         if (cv[i]) begin
            bundle.words[n[1:0]] = cand[i];
            n = n + 3'd1;
         end
      end
      bundle.count = n;
      bundle.load  = fire && (n != '0);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         exp_ff       <= '0;
         first_ff     <= 1'b1;
         held_v_ff    <= 1'b0;
         held_len_ff  <= '0;
         held_mark_ff <= 1'b0;
         loss_ff      <= 1'b0;
         fill_ff      <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         exp_ff       <= exp_in;
         first_ff     <= first_in;
         held_v_ff    <= held_v_in;
         held_len_ff  <= held_len_in;
         held_mark_ff <= held_mark_in;
         loss_ff      <= loss_in;
         fill_ff      <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      in_ff <= in_in;
   end

   `RFRA_ASSERT(a_held_after_first, clock, reset, !(held_v_ff && first_ff), "held packet before first packet")
   `RFRA_ASSERT(a_load_count, clock, reset, !bundle.load || (bundle.count <= 3'd4), "bundle holds more than four words")
   `RFRA_ASSERT_NEXT(a_hold_silent, clock, reset, fire && hold, held_v_ff && !loss_ff == !$past(loss0), "held packet not stored")
   `RFRA_ASSERT(a_frame_fits, clock, reset, {1'b0, fill_ff} <= rfra_pkg::FRAME_BYTES, "fill offset beyond frame")

endmodule

@@ rtl/core/rfra_out_queue.sv @@
// Output queue: stores the words of one item and hands them out in order.
// Depends on rfra_pkg and the assertion macro header.
`include "rtp_frame_reorder_assembler_core_defines.svh"

module rfra_out_queue (
   input  logic                 clock,
   input  logic                 reset,
   input  rfra_pkg::bundle_type bundle,
   output logic                 q_free,
   output logic                 rsp_valid,
   input  logic                 rsp_ready,
   output rfra_pkg::rsp_type    rsp_payload
);

   rfra_pkg::rsp_type [rfra_pkg::MAX_WORDS-1:0] words_ff, words_in;
   logic [rfra_pkg::CNT_W-1:0] cnt_ff, cnt_in;
   logic [1:0]                 rd_ff, rd_in;
   logic                       take;

   assign rsp_valid   = cnt_ff != '0;
   assign rsp_payload = words_ff[rd_ff];
   assign take        = rsp_valid && rsp_ready;
   assign q_free      = (cnt_ff == '0) || (take && (cnt_ff == 3'd1));

   // Advance on each delivered word, reload when the engine steps
   always_comb begin
      words_in = words_ff;
      cnt_in   = cnt_ff;
      rd_in    = rd_ff;
      if (take) begin
         cnt_in = cnt_ff - 3'd1;
         rd_in  = rd_ff + 2'd1;
      end
      if (bundle.load) begin
         words_in = bundle.words;
         cnt_in   = bundle.count;
         rd_in    = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
         rd_ff  <= '0;
      end else begin
         cnt_ff <= cnt_in;
         rd_ff  <= rd_in;
      end
   end

   always_ff @(posedge clock) begin
      words_ff <= words_in;
   end

   `RFRA_ASSERT(a_load_when_free, clock, reset, !bundle.load || q_free, "bundle loaded over pending words")
   `RFRA_ASSERT(a_cnt_range, clock, reset, cnt_ff <= 3'd4, "queue count out of range")
   `RFRA_ASSERT(a_last_at_end, clock, reset, !rsp_valid || (rsp_payload.last == (cnt_ff == 3'd1)), "last flag not on final word")

endmodule

@@ rtl/core/rtp_frame_reorder_assembler_core.sv @@
// Top level of the RTP frame reorder and assembly core.
// Depends on rfra_pkg, rfra_engine and rfra_out_queue.
//
//  channel | direction | handshake            | word
//  req     | in        | req_valid/req_ready  | rfra_pkg::req_type
//  rsp     | out       | rsp_valid/rsp_ready  | rfra_pkg::rsp_type
//
// A header is registered on acceptance and stepped once the output queue is free,
// in one pass, into up to four result words held in the output queue.
// Results come out one per cycle while rsp_ready is high; an item gives one
// to four results, or none.
// The queue frees on delivery of its last word, letting the next step load
// in that same cycle. A stalled rsp side holds the queue and then the input.
// Reset is synchronous and restores the tracking state.

module rtp_frame_reorder_assembler_core (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   output logic              req_ready,
   input  rfra_pkg::req_type req_payload,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output rfra_pkg::rsp_type rsp_payload
);

   rfra_pkg::bundle_type bundle;
   logic                 q_free;

   rfra_engine u_engine (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .q_free      (q_free),
      .bundle      (bundle)
   );

   rfra_out_queue u_out_queue (
      .clock       (clock),
      .reset       (reset),
      .bundle      (bundle),
      .q_free      (q_free),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

endmodule

@@ tb/rfra_reorder_monitor.sv @@
// Watches the header and command channels of the frame reorder core, predicts the
// command words of every accepted header and compares them. Depends on rfra_pkg.
module rfra_reorder_monitor import rfra_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_ready,
   input  req_type req_payload,
   input  logic    rsp_valid,
   input  logic    rsp_ready,
   input  rsp_type rsp_payload,
   output int      mismatches,
   output int      outstanding
);
   timeunit 1ns;
   timeprecision 1ps;

   localparam int DUE_DEPTH = 16;

   // Sequence tracking and frame fill state
   logic [SEQ_W-1:0] want_seq;
   logic             awaiting_first;
   logic             early_held;
   logic [LEN_W-1:0] early_len;
   logic             early_marker;
   logic             frame_lost;
   logic [OFF_W-1:0] frame_fill;

   // Command words of the header being stepped, and those still due on rsp
   rsp_type step_cmds [MAX_WORDS];
   int      step_n;
   rsp_type due_ring [DUE_DEPTH];
   int      due_rd;
   int      due_count;
   rsp_type head_cmd;
   bit      word_bad;

   function void emit(action_type act, logic [OFF_W-1:0] off, logic [OFF_W-1:0] flen);
      if (step_n < MAX_WORDS) begin
         step_cmds[step_n] = '{action: act, byte_offset: off, frame_length: flen, last: 1'b0};
         step_n++;
      end
   endfunction

   // Store one predicted word behind those already due
   function void due_add(rsp_type w);
      if (due_count < DUE_DEPTH) begin
         due_ring[(due_rd + due_count) % DUE_DEPTH] = w;
         due_count++;
      end else begin
         $display("%0t: prediction store full, expected room for %p got none", $time, w);
         mismatches++;
      end
   endfunction

   // Take the oldest predicted word
   function rsp_type due_take();
      rsp_type w;
      w         = due_ring[due_rd];
      due_rd    = (due_rd + 1) % DUE_DEPTH;
      due_count--;
      return w;
   endfunction

   // Append a packet unless the frame is lost or would overflow; close it on a marker
   function void place_in_frame(action_type act, logic [LEN_W-1:0] len, logic mark);
      logic [OFF_W:0] total;
      total = {1'b0, frame_fill} + {{(OFF_W+1-LEN_W){1'b0}}, len};
      if (!frame_lost) begin
         if (({{(16-LEN_W){1'b0}}, len} > MAX_PAYLOAD) || (total > FRAME_BYTES)) begin
            frame_lost = 1'b1;
         end else begin
            emit(act, frame_fill, '0);
            frame_fill = total[OFF_W-1:0];
         end
      end
      if (mark) begin
         if (!frame_lost) begin
            emit(ACT_COMPLETE, '0, frame_fill);
         end else begin
            emit(ACT_DROPPED, '0, '0);
         end
         frame_fill = '0;
         frame_lost = 1'b0;
      end
   endfunction

   // Step one header through the reorder logic and queue its command words
   function void step_reorder(req_type h);
      step_n = 0;
      if (awaiting_first) begin
         want_seq       = h.seq_no;
         awaiting_first = 1'b0;
      end
      if (early_held) begin
         // only the missing packet resolves the swap; anything else loses the held one
         if (h.seq_no != want_seq - 16'd2) begin
            frame_lost = 1'b1;
            early_held = 1'b0;
         end
      end else if (h.seq_no != want_seq) begin
         if (h.seq_no == want_seq + 16'd1) begin
            early_held   = 1'b1;
            early_len    = h.payload_len;
            early_marker = h.marker;
            want_seq     = h.seq_no + 16'd1;
            return;
         end
         frame_lost = 1'b1;
      end
      place_in_frame(ACT_APPEND_CUR, h.payload_len, h.marker);
      if (early_held) begin
         want_seq = h.seq_no + 16'd2;
         place_in_frame(ACT_APPEND_HELD, early_len, early_marker);
         early_held = 1'b0;
      end else begin
         want_seq = h.seq_no + 16'd1;
      end
      if (step_n > 0) begin
         step_cmds[step_n-1].last = 1'b1;
      end
      for (int i = 0; i < step_n; i++) begin
         due_add(step_cmds[i]);
      end
   endfunction

   function bit field_differs(string what, logic [OFF_W-1:0] want_v, logic [OFF_W-1:0] got_v);
      if (got_v !== want_v) begin
         $display("%0t: %s expected %0d got %0d", $time, what, want_v, got_v);
         return 1'b1;
      end
      return 1'b0;
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         want_seq       = '0;
         awaiting_first = 1'b1;
         early_held     = 1'b0;
         early_len      = '0;
         early_marker   = 1'b0;
         frame_lost     = 1'b0;
         frame_fill     = '0;
         mismatches     = 0;
         due_rd         = 0;
         due_count      = 0;
      end else begin
         if (req_valid && req_ready) begin
            step_reorder(req_payload);
         end
         // compare each delivered word with the oldest one due
         if (rsp_valid && rsp_ready) begin
            if (due_count == 0) begin
               $display("%0t: unexpected word, expected none got %p", $time, rsp_payload);
               mismatches++;
            end else begin
               head_cmd = due_take();
               word_bad = 1'b0;
               word_bad |= field_differs("action", OFF_W'(head_cmd.action),
                                         OFF_W'(rsp_payload.action));
               word_bad |= field_differs("byte_offset", head_cmd.byte_offset,
                                         rsp_payload.byte_offset);
               word_bad |= field_differs("frame_length", head_cmd.frame_length,
                                         rsp_payload.frame_length);
               word_bad |= field_differs("last", OFF_W'(head_cmd.last),
                                         OFF_W'(rsp_payload.last));
               if (word_bad) begin
                  mismatches++;
               end
            end
         end
      end
      outstanding = due_count;
   end

endmodule

@@ tb/rtp_frame_reorder_assembler_core_tb.sv @@
// Testbench top of the RTP frame reorder and assembly core: clock, reset, header
// stimulus and command back-pressure. Depends on rfra_pkg and rfra_reorder_monitor.
module rtp_frame_reorder_assembler_core_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import rfra_pkg::*;

   localparam int QUIET_LIMIT      = 2000;
   localparam int RSP_HOLD_CYCLES  = 300;
   localparam int TAIL_CYCLES      = 20;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_ready;
   req_type req_payload = '0;
   logic    rsp_valid;
   logic    rsp_ready = 1'b0;
   rsp_type rsp_payload;

   int          mismatches;
   int          outstanding;
   int          send_idle = 28;
   int          recv_idle = 57;
   bit          hold_request = 1'b0;
   int          headers_sent = 0;
   int          quiet_cycles = 0;
   logic [15:0] gen_seq;
   int          bound [3] = '{90, 160, 230};

   always #5ns clock = ~clock;

   rtp_frame_reorder_assembler_core uut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   rfra_reorder_monitor monitor (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload),
      .mismatches  (mismatches),
      .outstanding (outstanding)
   );

   // Give up when neither channel moves a word for too long
   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
      if (quiet_cycles >= QUIET_LIMIT) begin
         $display("%0t: no handshake for %0d cycles", $time, QUIET_LIMIT);
         $display("== FAIL ==");
         $finish;
      end
   end

   // Command side back-pressure, with one long hold-off on request
   initial begin
      forever begin
         @(posedge clock);
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_ready <= 1'b0;
            repeat (RSP_HOLD_CYCLES) @(posedge clock);
         end
         rsp_ready <= ($urandom_range(99) >= recv_idle);
      end
   end

   function automatic logic [LEN_W-1:0] pick_len();
      int roll;
      roll = $urandom_range(99);
      if (roll < 60) begin
         return LEN_W'($urandom_range(2047));
      end else if (roll < 80) begin
         return LEN_W'($urandom_range(64));
      end else if (roll < 90) begin
         return '1;
      end
      return '0;
   endfunction

   // Offer one header word and hold it until accepted
   task automatic send_header(input logic [15:0] seq, input logic mark,
                              input logic [LEN_W-1:0] len);
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_payload <= '{seq_no: seq, marker: mark, payload_len: len};
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      headers_sent++;
   endtask

   // One frame of consecutive packets, sometimes swapped, thinned, repeated or noisy
   task automatic send_frame();
      logic [15:0]      seqs [8];
      logic             marks [8];
      logic [LEN_W-1:0] lens [8];
      logic [15:0]      ts;
      logic             tm;
      logic [LEN_W-1:0] tl;
      int               n;
      int               kind;
      int               j;
      n = $urandom_range(6, 1);
      for (int i = 0; i < n; i++) begin
         seqs[i]  = gen_seq + 16'(i);
         marks[i] = (i == n - 1);
         lens[i]  = pick_len();
      end
      gen_seq = gen_seq + 16'(n);
      kind = $urandom_range(99);
      j = (n > 1) ? $urandom_range(n - 2) : 0;
      if (kind < 15 && n > 1) begin
         // swap two neighbours
         ts = seqs[j];  seqs[j]  = seqs[j+1];  seqs[j+1]  = ts;
         tm = marks[j]; marks[j] = marks[j+1]; marks[j+1] = tm;
         tl = lens[j];  lens[j]  = lens[j+1];  lens[j+1]  = tl;
      end else if (kind < 23 && n > 1) begin
         // drop one packet
         for (int i = j; i < n - 1; i++) begin
            seqs[i] = seqs[i+1]; marks[i] = marks[i+1]; lens[i] = lens[i+1];
         end
         n--;
      end else if (kind < 28) begin
         // repeat one packet
         for (int i = n; i > j; i--) begin
            seqs[i] = seqs[i-1]; marks[i] = marks[i-1]; lens[i] = lens[i-1];
         end
         n++;
      end else if (kind < 33) begin
         // jump to a far sequence number for the next frame
         gen_seq = 16'($urandom);
      end else if (kind < 38) begin
         seqs[j]  = 16'($urandom);
         marks[j] = 1'($urandom);
         lens[j]  = LEN_W'($urandom);
      end
      for (int i = 0; i < n; i++) begin
         send_header(seqs[i], marks[i], lens[i]);
      end
   endtask

   // Fill the frame buffer to the brim, then close it or spill over by one byte
   task automatic send_full_frame(input bit spill);
      send_header(gen_seq, 1'b1, '0);
      gen_seq++;
      repeat (32) begin
         send_header(gen_seq, 1'b0, '1);
         gen_seq++;
      end
      send_header(gen_seq, 1'b0, LEN_W'(32));
      gen_seq++;
      send_header(gen_seq, 1'b1, spill ? LEN_W'(1) : LEN_W'(0));
      gen_seq++;
   endtask

   initial begin
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // first packet, swap across the wrap, swap with marker
      send_header(16'd65533, 1'b0, 11'd0);
      send_header(16'd65534, 1'b0, 11'd2047);
      send_header(16'd0,     1'b0, 11'd100);
      send_header(16'd65535, 1'b0, 11'd5);
      send_header(16'd2,     1'b1, 11'd7);
      send_header(16'd1,     1'b0, 11'd3);
      // held packet lost to a wrong arrival, then dropped frame
      send_header(16'd4,     1'b1, 11'd9);
      send_header(16'd9,     1'b0, 11'd11);
      send_header(16'd10,    1'b1, 11'd0);
      // empty single-packet frame
      send_header(16'd11,    1'b1, 11'd0);
      // both swapped packets carry markers
      send_header(16'd13,    1'b1, 11'd4);
      send_header(16'd12,    1'b1, 11'd6);
      // plain gap
      send_header(16'd14,    1'b0, 11'd1);
      send_header(16'd17,    1'b0, 11'd1);
      send_header(16'd18,    1'b1, 11'd1);
      // repeated packet
      send_header(16'd19,    1'b0, 11'd20);
      send_header(16'd19,    1'b1, 11'd20);
      // held packet, then a far arrival with marker
      send_header(16'd21,    1'b0, 11'd5);
      send_header(16'd25,    1'b1, 11'd5);
      gen_seq = 16'd26;

      for (int phase = 0; phase < 3; phase++) begin
         case (phase)
            0: begin
               send_idle = 28;
               recv_idle = 57;
            end
            1: begin
               send_idle = 57;
               recv_idle = 28;
               hold_request = 1'b1;
               send_full_frame(1'b0);
            end
            default: begin
               send_idle = 0;
               recv_idle = 0;
               send_full_frame(1'b1);
            end
         endcase
         while (headers_sent < bound[phase]) begin
            send_frame();
         end
      end
      req_valid <= 1'b0;

      // drain the command words still due, then let the core settle
      while (outstanding != 0) @(posedge clock);
      repeat (TAIL_CYCLES) @(posedge clock);
      if (mismatches == 0 && outstanding == 0) begin
         $display("== PASS ==");
      end else begin
         $display("== FAIL ==");
      end
      $finish;
   end

endmodule
